// ----- rtl/msi_pkg.sv -----
// shared constants and types for the multi-axis step interpolator
package msi_pkg;

  localparam int FRAC_BITS_DEF = 6;
  localparam int ANGLE_W = 16;
  localparam int SPAN_W = 10;
  localparam int STEP_W = 16;
  localparam int DELTA_W = 10;
  localparam int AXES = 3;
  // difference of two angles
  localparam int DIFF_W = ANGLE_W + 1;
  // step * diff
  localparam int PROD_W = DIFF_W + STEP_W + 1;
  // quotient magnitude bound: product magnitude itself
  localparam int QUO_W = PROD_W;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // per-lane status passed to the merge stage
  typedef struct packed {
    logic [DELTA_W-1:0] whole;
    logic same;
  } lane_stat_t;

endpackage

// ----- rtl/msi_lane.sv -----
// one joint lane: distance, product, pipelined restoring divider, saturating add
module msi_lane
  import msi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  angle_t cur,
  input  angle_t tgt,
  input  logic [SPAN_W-1:0] span,
  input  logic [STEP_W-1:0] step_size,
  output angle_t nxt,
  output lane_stat_t stat
);

  localparam int DIV_W = SPAN_W + FRAC_BITS;
  localparam int MAG_W = PROD_W - 1;
  localparam int STAGES = MAG_W;
  localparam int DW = DIFF_W - FRAC_BITS;

  // stage 0: difference, status, product
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] adiff;
  logic [DW-1:0] wd;
  logic signed [PROD_W-1:0] prod;
  assign diff = DIFF_W'(tgt) - DIFF_W'(cur);
  assign adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign wd = adiff[DIFF_W-1:FRAC_BITS];
  assign prod = PROD_W'($signed({1'b0, step_size})) * PROD_W'(diff);

  // per-stage pipeline registers
  logic [MAG_W-1:0] rem [STAGES+1];
  logic [MAG_W-1:0] quo [STAGES+1];
  logic [DIV_W-1:0] dvs [STAGES+1];
  logic neg [STAGES+1];
  logic zero [STAGES+1];
  angle_t pcur [STAGES+1];
  angle_t ptgt [STAGES+1];
  lane_stat_t pst [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
      quo[0] <= '0;
      dvs[0] <= DIV_W'(span) << FRAC_BITS;
      neg[0] <= prod[PROD_W-1];
      zero[0] <= (span == '0);
      pcur[0] <= cur;
      ptgt[0] <= tgt;
      pst[0].same <= (cur == tgt);
      pst[0].whole <= (wd > DW'((1 << DELTA_W) - 1)) ? '1 : DELTA_W'(wd);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < STAGES; s++) begin : g_div
    localparam int B = STAGES - 1 - s;
    logic [MAG_W+DIV_W-1:0] sh;
    logic fit;
    assign sh = (MAG_W+DIV_W)'(dvs[s]) << B;
    assign fit = (MAG_W+DIV_W)'(rem[s]) >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= fit ? MAG_W'((MAG_W+DIV_W)'(rem[s]) - sh) : rem[s];
        quo[s+1] <= quo[s] | (MAG_W'(fit) << B);
        dvs[s+1] <= dvs[s];
        neg[s+1] <= neg[s];
        zero[s+1] <= zero[s];
        pcur[s+1] <= pcur[s];
        ptgt[s+1] <= ptgt[s];
        pst[s+1] <= pst[s];
      end
    end
  end

  // final add and saturation
  logic signed [PROD_W+1:0] mv;
  logic signed [PROD_W+1:0] sum;
  assign mv = neg[STAGES] ? -$signed({3'b000, quo[STAGES]}) : $signed({3'b000, quo[STAGES]});
  assign sum = mv + (PROD_W+2)'(pcur[STAGES]);

  always_comb begin
    if (zero[STAGES]) nxt = ptgt[STAGES];
    else if (sum > (PROD_W+2)'(32767)) nxt = 16'sh7fff;
    else if (sum < -(PROD_W+2)'(32768)) nxt = 16'sh8000;
    else nxt = angle_t'(sum[ANGLE_W-1:0]);
  end
  assign stat = pst[STAGES];

endmodule

// ----- rtl/msi_merge.sv -----
// merge of lane status: largest distance and all-at-target flag
module msi_merge
  import msi_pkg::*;
(
  input  lane_stat_t st [AXES],
  output logic [DELTA_W-1:0] largest,
  output logic all_same
);
  always_comb begin
    largest = '0;
    all_same = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (st[i].whole > largest) largest = st[i].whole;
      all_same = all_same & st[i].same;
    end
  end
endmodule

// ----- rtl/multi_axis_step_interpolator.sv -----
// top level of the multi-axis step interpolator
//
// channel   dir  beat contents (low bits first)
// s_axis    in   current_a, current_b, current_c, target_a, target_b, target_c, span, step_size
// m_axis    out  next_a, next_b, next_c, largest_delta, at_target
//
// a beat is accepted every cycle while the pipe moves; on its way to m_axis it passes the product register,
// then 33 divider stages, one quotient bit each, then the output
// register, where merge and saturation settle
// the pipe advances only when the output register is empty or being drained
// rst clears the valid bits of every stage; payload registers are not reset
// a stalled output holds every stage, so s_axis_tready follows m_axis_tready
module multi_axis_step_interpolator
  import msi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // current_a, current_b, current_c, target_a, target_b, target_c, span, step_size
  input  logic [127:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // next_a, next_b, next_c, largest_delta, at_target, zero pad
  output logic [63:0] m_axis_tdata
);

  localparam int LAT = PROD_W;  // input reg + divider stages

  logic en;
  logic [LAT-1:0] vld;
  angle_t nxt [AXES];
  lane_stat_t st [AXES];
  logic [DELTA_W-1:0] largest;
  logic all_same;

  // whole pipe moves together; output register is the last stage
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
      m_axis_tvalid <= vld[LAT-1];
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    msi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk),
      .en(en),
      .cur(angle_t'(s_axis_tdata[16*i +: 16])),
      .tgt(angle_t'(s_axis_tdata[48 + 16*i +: 16])),
      .span(s_axis_tdata[105:96]),
      .step_size(s_axis_tdata[121:106]),
      .nxt(nxt[i]),
      .stat(st[i])
    );
  end

  msi_merge u_merge (.st(st), .largest(largest), .all_same(all_same));

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {5'd0, all_same, largest, nxt[2], nxt[1], nxt[0]};
    end
  end

  // output held under stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // ready tracks the output side
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while stalled");
  // the output becomes valid on a move only if the last stage held a valid beat
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && !vld[LAT-1] |=> !m_axis_tvalid)
    else $error("output beat invented");

endmodule

// ----- tb/msi_checker.sv -----
// checker for the multi-axis step interpolator: predicts each output beat and compares it
module msi_checker
  import msi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic              at_target;
    logic [DELTA_W-1:0] largest;
    angle_t            nc;
    angle_t            nb;
    angle_t            na;
  } step_out_t;

  step_out_t expected_steps[$];

  function automatic angle_t next_angle(longint cur, longint tgt, longint span, longint step);
    longint res;
    if (span == 0) begin
      res = tgt;
    end else begin
      // sv division truncates toward zero like c
      res = cur + (step * (tgt - cur)) / (span * (longint'(1) << FB));
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return angle_t'(res);
  endfunction

  function automatic step_out_t interpolate(logic [127:0] d);
    step_out_t r;
    longint cur[3];
    longint tgt[3];
    longint span;
    longint step;
    longint gap;
    longint best;
    angle_t nx[3];
    best = 0;
    r.at_target = 1'b1;
    span = longint'(d[105:96]);
    step = longint'(d[121:106]);
    for (int j = 0; j < 3; j++) begin
      cur[j] = longint'($signed(d[16*j +: 16]));
      tgt[j] = longint'($signed(d[48+16*j +: 16]));
      gap = cur[j] - tgt[j];
      if (gap < 0) gap = -gap;
      gap = gap >>> FB;
      if (gap > best) best = gap;
      if (cur[j] != tgt[j]) r.at_target = 1'b0;
      nx[j] = next_angle(cur[j], tgt[j], span, step);
    end
    if (best > 1023) best = 1023;
    r.largest = best[DELTA_W-1:0];
    r.na = nx[0];
    r.nb = nx[1];
    r.nc = nx[2];
    return r;
  endfunction

  assign pending = expected_steps.size();

  always @(posedge clk) begin
    step_out_t got;
    step_out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_steps.push_back(interpolate(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = step_out_t'(m_axis_tdata[58:0]);
        if (expected_steps.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected output beat %h", m_axis_tdata);
        end else begin
          want = expected_steps.pop_front();
          if (got != want || m_axis_tdata[63:59] != 0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: next %0d %0d %0d delta %0d at %0b, exp %0d %0d %0d delta %0d at %0b",
                got.na, got.nb, got.nc, got.largest, got.at_target,
                want.na, want.nb, want.nc, want.largest, want.at_target);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_multi_axis_step_interpolator.sv -----
// testbench top for the multi-axis step interpolator: stimulus, stalls and verdict
module tb_multi_axis_step_interpolator;
  import msi_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  // idle percentages for the current phase
  int           send_idle = 0;
  int           recv_idle = 0;
  // long receiver hold-off, counted down in its own process
  int           hold_cycles = 0;
  bit           stim_done = 1'b0;

  localparam int LIMIT = 400000;

  always #6 clk = ~clk;

  multi_axis_step_interpolator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  msi_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, or a long hold-off when one is armed
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // random angle biased toward the extremes
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'h7fff - 16'($urandom_range(3));
      1: return 16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // pack one beat: currents, targets, span, step from the low bits up
  function automatic logic [127:0] make_beat(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc,
      logic [15:0] ta, logic [15:0] tb, logic [15:0] tc, logic [9:0] span, logic [15:0] step);
    return {6'b0, step, span, tc, tb, ta, cc, cb, ca};
  endfunction

  function automatic logic [127:0] random_beat();
    logic [15:0] cur[3];
    logic [15:0] tgt[3];
    logic [9:0]  span;
    logic [15:0] step;
    for (int j = 0; j < 3; j++) begin
      cur[j] = pick_angle();
      case ($urandom_range(3))
        0: tgt[j] = cur[j];
        1: tgt[j] = cur[j] + 16'($urandom_range(2000)) - 16'd1000;
        default: tgt[j] = pick_angle();
      endcase
    end
    case ($urandom_range(4))
      0: span = 10'd0;
      1: span = 10'h3ff;
      default: span = 10'($urandom);
    endcase
    step = ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom);
    return make_beat(cur[0], cur[1], cur[2], tgt[0], tgt[1], tgt[2], span, step);
  endfunction

  // offer one beat, with random idle cycles first, and wait for acceptance
  task automatic send_beat(logic [127:0] beat);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero span, zero step, overshoot, extremes, all at target
    send_beat(make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0, 16'd0));
    send_beat(make_beat(16'h8000, 16'h7fff, 16'h0040, 16'h7fff, 16'h8000, 16'hffc0, 10'd0, 16'd64));
    send_beat(make_beat(16'h8000, 16'h7fff, 16'h1234, 16'h7fff, 16'h8000, 16'h1234, 10'd1, 16'd0));
    send_beat(make_beat(16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0100, 10'd1, 16'hffff));
    send_beat(make_beat(16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0100, 10'h3ff, 16'hffff));
    send_beat(make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0640, 16'hf9c0, 16'h003f, 10'd25, 16'd64));
    send_beat(make_beat(16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 10'h3ff, 16'hffff));
    send_beat(make_beat(16'hffff, 16'h0001, 16'h0000, 16'h0001, 16'hffff, 16'h0000, 10'd1, 16'd1));
    send_beat(make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0fff, 16'hf001, 16'h0000, 10'd1, 16'd200));
    send_beat(make_beat(16'haaaa, 16'h5555, 16'hffff, 16'h5555, 16'haaaa, 16'h0000, 10'h2aa, 16'h5555));
    send_beat(make_beat(16'h5555, 16'haaaa, 16'h0000, 16'haaaa, 16'h5555, 16'hffff, 10'h155, 16'haaaa));

    // long receiver hold-off while the sender keeps offering, so the pipe fills
    hold_cycles <= 150;
    for (int k = 0; k < 80; k++) send_beat(random_beat());
    // sender pause until everything has come back
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 62) : 0;
      recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 62) : 0;
      for (int k = 0; k < 230; k++) send_beat(random_beat());
      if (ph == 1) drain();
    end
    s_axis_tvalid <= 1'b0;
    recv_idle = 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
